@@ sv/ssns_pkg.sv @@
`timescale 1ns / 1ps
// Package: item layouts and constants for the sixteen-step note sequencer.
package ssns_pkg;

    localparam int IN_W  = 24;
    localparam int OUT_W = 24;
    localparam int CFG_W = 16;

    localparam logic [15:0] TICK_RESET        = 16'd4000;
    localparam logic [15:0] TICK_MAX          = 16'hFFFF;
    localparam logic [15:0] TEMPO_SCALE_RESET = 16'd3000;
    localparam logic [7:0]  NOTE_TOP          = 8'd128;
    localparam logic [7:0]  NOTE_MAX_PLAIN    = 8'd127;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic [4:0]        pad;
        logic [7:0]        tempo_bpm;
        logic signed [7:0] encoder_delta;
        logic              prev_button;
        logic              next_button;
        logic              play_button;
    } ssns_in_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [0:0] pad;
        logic [7:0] edited_note;
        logic [3:0] shown_step;
        logic       gate;
        logic [7:0] sounding_note;
        logic       step_trigger;
        logic       playing;
    } ssns_out_t;

endpackage

@@ sv/sixteen_step_note_sequencer.sv @@
`timescale 1ns / 1ps
// Top level: step sequencer with play timing, edit mode and note store.
//
//  channel | direction | handshake             | payload
//  s_      | in        | s_tvalid / s_tready   | s_tdata  (one tick item)
//  m_      | out       | m_tvalid / m_tready   | m_tdata  (one result item)
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_data (tempo_scale)
//
// An item is registered on entry, updated through combinational logic and
// registered again on exit; one item per cycle sustained while m_ is ready.
// The note store read-modify-write and the 24-bit tick times tempo compare
// both close in the update logic between the entry and exit registers.
// Synchronous active-low reset clears the valid flags and sequencer state, not the data registers;
// tick counter starts at 4000. A stalled m_ side holds the result; the input stage keeps one item waiting.
module sixteen_step_note_sequencer #(
    parameter int STEPS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // play_button, next_button, prev_button, encoder_delta[7:0], tempo_bpm[7:0], zero pad
    input  logic [ssns_pkg::IN_W-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // playing, step_trigger, sounding_note[7:0], gate, shown_step[3:0], edited_note[7:0], zero pad
    output logic [ssns_pkg::OUT_W-1:0] m_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    // tempo_scale
    input  logic [ssns_pkg::CFG_W-1:0] cfg_data
);
    import ssns_pkg::*;

    localparam int PW = $clog2(STEPS + 1);
    localparam int IW = $clog2(STEPS);
    localparam logic [PW-1:0] POS_LAST  = PW'(STEPS - 1);
    localparam logic [PW-1:0] POS_STEPS = PW'(STEPS);

    logic            in_valid_reg;
    ssns_in_t        in_reg;
    logic            out_valid_reg;
    ssns_out_t       out_reg, out_next;
    logic            advance;

    logic [7:0]      note_reg [STEPS];
    logic [PW-1:0]   pos_reg, pos_next;
    logic            mode_reg, mode_next;
    logic            play_prev_reg;
    logic            next_prev_reg, next_prev_next;
    logic            prev_prev_reg, prev_prev_next;
    logic [15:0]     tick_reg, tick_next;
    logic [7:0]      tone_reg, tone_next;
    logic            gate_reg, gate_next;
    logic [3:0]      led_reg, led_next;
    logic [15:0]     scale_reg;

    logic            play_edge;
    logic [PW-1:0]   pos_base;
    logic [PW-1:0]   pos_wrap;
    logic [PW-1:0]   pos_edit;
    logic [PW-1:0]   pos_sel;
    logic [PW+3:0]   pos_ext;
    logic [7:0]      note_rd;
    logic [23:0]     product;
    logic            due;
    logic [15:0]     tick_base;
    logic signed [9:0] sum;
    logic [7:0]      sum_sat;
    logic            note_we;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        play_edge = in_reg.play_button && !play_prev_reg;
        mode_next = mode_reg ^ play_edge;
        pos_base  = play_edge ? '0 : pos_reg;
        pos_wrap  = (pos_base >= POS_STEPS) ? '0 : pos_base;

        pos_edit       = pos_wrap;
        next_prev_next = next_prev_reg;
        prev_prev_next = prev_prev_reg;
        if (in_reg.next_button != next_prev_reg) begin
            next_prev_next = in_reg.next_button;
            if (in_reg.next_button) begin
                pos_edit = (pos_wrap == POS_LAST) ? '0 : pos_wrap + PW'(1);
            end
        end else if (in_reg.prev_button != prev_prev_reg) begin
            prev_prev_next = in_reg.prev_button;
            if (in_reg.prev_button) begin
                pos_edit = (pos_wrap == '0) ? POS_LAST : pos_wrap - PW'(1);
            end
        end

        pos_sel = mode_next ? pos_wrap : pos_edit;
        note_rd = note_reg[pos_sel[IW-1:0]];
        pos_ext = {4'd0, pos_sel};

        product = {8'd0, tick_reg} * {16'd0, in_reg.tempo_bpm};
        due     = product > {8'd0, scale_reg};

        sum = $signed({2'b00, note_rd}) + 10'(in_reg.encoder_delta);
        if (sum > $signed({2'b00, NOTE_MAX_PLAIN})) begin
            sum_sat = NOTE_TOP;
        end else if (sum < 10'sd1) begin
            sum_sat = 8'd0;
        end else begin
            sum_sat = sum[7:0];
        end

        tone_next = tone_reg;
        gate_next = gate_reg;
        led_next  = led_reg;
        tick_next = tick_reg;
        pos_next  = pos_base;
        note_we   = 1'b0;
        out_next  = '0;

        if (mode_next) begin
            tick_base = due ? 16'd0 : tick_reg;
            tick_next = (tick_base == TICK_MAX) ? tick_base : tick_base + 16'd1;
            if (due) begin
                tone_next = note_rd;
                gate_next = note_rd != 8'd0;
                led_next  = pos_ext[3:0];
                pos_next  = pos_wrap + PW'(1);
            end
            out_next.step_trigger = due;
        end else begin
            tick_base = tick_reg;
            gate_next = 1'b0;
            pos_next  = pos_edit;
            if (in_reg.next_button != next_prev_reg || in_reg.prev_button != prev_prev_reg) begin
                led_next = pos_ext[3:0];
            end
            note_we = 1'b1;
            out_next.edited_note = sum_sat;
        end

        out_next.playing       = mode_next;
        out_next.sounding_note = tone_next;
        out_next.gate          = gate_next;
        out_next.shown_step    = led_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            mode_reg      <= 1'b0;
            play_prev_reg <= 1'b0;
            next_prev_reg <= 1'b0;
            prev_prev_reg <= 1'b0;
            tick_reg      <= TICK_RESET;
            tone_reg      <= '0;
            gate_reg      <= 1'b0;
            led_reg       <= '0;
            scale_reg     <= TEMPO_SCALE_RESET;
            for (int i = 0; i < STEPS; i++) begin
                note_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                scale_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_reg       <= ssns_in_t'(s_tdata);
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
                pos_reg       <= pos_next;
                mode_reg      <= mode_next;
                play_prev_reg <= in_reg.play_button;
                tick_reg      <= tick_next;
                tone_reg      <= tone_next;
                gate_reg      <= gate_next;
                led_reg       <= led_next;
                if (!mode_next) begin
                    next_prev_reg <= next_prev_next;
                    prev_prev_reg <= prev_prev_next;
                end
                if (note_we) begin
                    note_reg[pos_sel[IW-1:0]] <= sum_sat;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // a triggered step gates on exactly when its note is nonzero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.step_trigger) |-> (out_reg.gate == (out_reg.sounding_note != 8'd0)))
        else $error("gate does not follow triggered note");

    // edit mode: no trigger, no gate
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.playing) |-> (!out_reg.step_trigger && !out_reg.gate))
        else $error("trigger or gate in edit mode");

    // play mode reports no edited note
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.playing) |-> (out_reg.edited_note == 8'd0))
        else $error("edited note in play mode");

    // edited note never passes the saturation limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.edited_note <= NOTE_TOP))
        else $error("edited note out of range");
`endif

endmodule
